@@ hw/rtl/ute_pkg.sv @@
// Shared types, constants and helper functions of the UTF-8 text escape encoder.
// Used by ute_ctrl, ute_datapath and utf8_text_escape_encoder_top; no dependencies.
package ute_pkg;

  // Length counter and capacity widths
  localparam int LenBits = 16;
  localparam int CapBits = 16;

  // Escape modes
  localparam logic [1:0] ModeHtml = 2'd0;
  localparam logic [1:0] ModeXml  = 2'd1;
  localparam logic [1:0] ModeJs   = 2'd2;
  localparam logic [1:0] ModeJson = 2'd3;

  // Configuration register indexes
  localparam logic RegMode = 1'b0;
  localparam logic RegCap  = 1'b1;

  localparam logic [CapBits-1:0] CapReset = 16'd4096;

  // Room kept free before each character
  localparam logic [2:0] ReserveWide = 3'd6;
  localparam logic [2:0] ReserveJson = 3'd2;
  // Replacement of a byte by U+E000 plus the byte: three bytes, lead EE
  localparam logic [2:0] ReplLen  = 3'd3;
  localparam logic [7:0] ReplLead = 8'hEE;
  localparam logic [7:0] ContMark = 8'h80;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // latch the input word
    logic flush_start;  // move held bytes into the flush queue
    logic load_pend;    // next held byte becomes a replaced character
    logic load_fresh;   // current byte becomes a one-byte character
    logic load_full;    // held bytes plus current byte form a character
    logic append;       // hold the current byte as a continuation
    logic start_pend;   // hold the current byte as a lead
    logic build;        // form the escaped text of the character
    logic emit;         // send the next escaped byte
    logic emit_ovf;     // send the overflow word
    logic emit_term;    // send the terminator word
    logic clear_str;    // reset per-string state
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic eos;          // latched word ends the string
    logic ovf_seen;     // string already overflowed
    logic pend_nz;      // bytes are held
    logic cont_ok;      // current byte continues the held character
    logic complete;     // current byte completes it
    logic lead_ok;      // current byte starts a multi-byte character
    logic flush_more;   // held bytes still to flush
    logic fits;         // character fits the capacity
    logic len_ge_cap;   // no room for the terminator
    logic esc_last;     // next escaped byte is the last one
    logic out_free;     // output register can take a word
  } sts_t;

  // Byte count of a character from its lead byte, zero if it cannot lead
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] n;
    begin
      if (lead inside {[8'hC2:8'hDF]}) n = 3'd2;
      else if (lead inside {[8'hE0:8'hEF]}) n = 3'd3;
      else if (lead inside {[8'hF0:8'hF4]}) n = 3'd4;
      else n = 3'd0;
      return n;
    end
  endfunction

  // Whether b is a legal continuation at position pos of the character
  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    begin
      lo = 8'h80;
      hi = 8'hBF;
      if (pos == 2'd1) begin
        if (lead == 8'hE0) lo = 8'hA0;
        else if (lead == 8'hED) hi = 8'h9F;
        else if (lead == 8'hF0) lo = 8'h90;
        else if (lead == 8'hF4) hi = 8'h8F;
      end
      return (b >= lo) && (b <= hi);
    end
  endfunction

endpackage

@@ hw/rtl/ute_datapath.sv @@
// Datapath of the UTF-8 text escape encoder: config registers, held bytes,
// character register, escape builder, length counter and output register.
// Depends on ute_pkg; driven by ute_ctrl through ute_pkg::cmd_t.
module ute_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ute_pkg::CapBits-1:0]  cfg_data_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_string_i,
  input  ute_pkg::cmd_t                cmd_i,
  output ute_pkg::sts_t                sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_byte_o,
  output logic                         is_last_o,
  output logic                         overflow_o,
  output logic [15:0]                  total_length_o
);

  logic [1:0]                   mode_q;
  logic [ute_pkg::CapBits-1:0]  cap_q;
  logic [7:0]                   cur_byte_q;
  logic                         cur_eos_q;
  logic [7:0]                   pend_q [3];
  logic [1:0]                   pend_cnt_q;
  logic [1:0]                   flush_n_q;
  logic [1:0]                   flush_idx_q;
  logic [ute_pkg::LenBits-1:0]  len_q;
  logic                         ovf_seen_q;
  logic [31:0]                  ch_q;
  logic [31:0]                  ch_d;
  logic [2:0]                   ch_n_q;
  logic [2:0]                   ch_n_d;
  logic                         ch_repl_q;
  logic [47:0]                  esc_q;
  logic [47:0]                  esc_d;
  logic [2:0]                   esc_left_q;
  logic [2:0]                   esc_len_d;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q;
  logic                         out_last_q;
  logic                         out_ovf_q;
  logic [15:0]                  out_total_q;

  logic [7:0]  lead;
  logic [2:0]  want;
  logic [7:0]  c;
  logic        is_ctrl;
  logic        repl_eff;
  logic [2:0]  reserve;
  logic [2:0]  need;
  logic [ute_pkg::LenBits:0] len_need;

  // Classify the current byte against the held character
  assign lead = pend_q[0];
  assign want = ute_pkg::seq_len(lead);

  // Character attributes and capacity check
  assign c        = ch_q[31:24];
  assign is_ctrl  = (ch_n_q == 3'd1) &&
                    (((c < 8'h20) && (c != 8'h09) && (c != 8'h0D) && (c != 8'h0A)) ||
                     (c == 8'h7F));
  assign repl_eff = ch_repl_q || is_ctrl;
  assign reserve  = (mode_q == ute_pkg::ModeJson) ? ute_pkg::ReserveJson
                                                  : ute_pkg::ReserveWide;
  always_comb begin
    need = repl_eff ? ute_pkg::ReplLen : ch_n_q;
    if (need < reserve) need = reserve;
  end
  assign len_need = {1'b0, len_q} + {{(ute_pkg::LenBits-2){1'b0}}, need};

  always_comb begin
    sts_o            = '0;
    sts_o.eos        = cur_eos_q;
    sts_o.ovf_seen   = ovf_seen_q;
    sts_o.pend_nz    = (pend_cnt_q != 2'd0);
    sts_o.cont_ok    = ute_pkg::cont_ok(lead, pend_cnt_q, cur_byte_q);
    sts_o.complete   = ({1'b0, pend_cnt_q} + 3'd1) >= want;
    sts_o.lead_ok    = (ute_pkg::seq_len(cur_byte_q) != 3'd0);
    sts_o.flush_more = (flush_idx_q < flush_n_q);
    sts_o.fits       = len_need <
                       {{(ute_pkg::LenBits+1-ute_pkg::CapBits){1'b0}}, cap_q};
    sts_o.len_ge_cap = {1'b0, len_q} >=
                       {{(ute_pkg::LenBits+1-ute_pkg::CapBits){1'b0}}, cap_q};
    sts_o.esc_last   = (esc_left_q == 3'd1);
    sts_o.out_free   = ~out_valid_q || out_ready_i;
  end

  // Select the next character: held byte, fresh byte or completed sequence
  always_comb begin
    ch_d   = ch_q;
    ch_n_d = ch_n_q;
    if (cmd_i.load_pend) begin
      ch_d   = {pend_q[flush_idx_q], 24'h0};
      ch_n_d = 3'd1;
    end else if (cmd_i.load_fresh) begin
      ch_d   = {cur_byte_q, 24'h0};
      ch_n_d = 3'd1;
    end else if (cmd_i.load_full) begin
      ch_d   = {lead,
                (pend_cnt_q == 2'd1) ? cur_byte_q : pend_q[1],
                (pend_cnt_q == 2'd2) ? cur_byte_q : pend_q[2],
                (pend_cnt_q == 2'd3) ? cur_byte_q : 8'h00};
      ch_n_d = want;
    end
  end

  // Build the escaped text, first byte in the top byte lane
  always_comb begin
    esc_d     = {ch_q, 16'h0};
    esc_len_d = ch_n_q;
    if (repl_eff) begin
      esc_d     = {ute_pkg::ReplLead, ute_pkg::ContMark | {6'b0, c[7:6]},
                   ute_pkg::ContMark | {2'b0, c[5:0]}, 24'h0};
      esc_len_d = ute_pkg::ReplLen;
    end else begin
      case (mode_q)
        ute_pkg::ModeHtml, ute_pkg::ModeXml: begin
          case (c)
            8'h3C: begin esc_d = {"&lt;", 16'h0};  esc_len_d = 3'd4; end
            8'h3E: begin esc_d = {"&gt;", 16'h0};  esc_len_d = 3'd4; end
            8'h26: begin esc_d = {"&amp;", 8'h0};  esc_len_d = 3'd5; end
            8'h22: begin esc_d = "&quot;";         esc_len_d = 3'd6; end
            8'h27: begin
              esc_d     = (mode_q == ute_pkg::ModeXml) ? "&apos;" : "&#x27;";
              esc_len_d = 3'd6;
            end
            default: ;
          endcase
        end
        ute_pkg::ModeJs: begin
          case (c)
            8'h27: begin esc_d = {"\\'", 32'h0};  esc_len_d = 3'd2; end
            8'h22: begin esc_d = {"\\\"", 32'h0}; esc_len_d = 3'd2; end
            8'h0D: begin esc_d = {"\\r", 32'h0};  esc_len_d = 3'd2; end
            8'h0A: begin esc_d = {"\\n", 32'h0};  esc_len_d = 3'd2; end
            8'hE2: begin
              // Line and paragraph separators
              if (ch_n_q == 3'd3 && ch_q[23:16] == 8'h80 && ch_q[15:8] == 8'hA8) begin
                esc_d     = "\\u2028";
                esc_len_d = 3'd6;
              end else if (ch_n_q == 3'd3 && ch_q[23:16] == 8'h80 &&
                           ch_q[15:8] == 8'hA9) begin
                esc_d     = "\\u2029";
                esc_len_d = 3'd6;
              end
            end
            default: ;
          endcase
        end
        default: begin
          case (c)
            8'h22: begin esc_d = {"\\\"", 32'h0}; esc_len_d = 3'd2; end
            8'h5C: begin esc_d = {"\\\\", 32'h0}; esc_len_d = 3'd2; end
            8'h0D: begin esc_d = {"\\r", 32'h0};  esc_len_d = 3'd2; end
            8'h0A: begin esc_d = {"\\n", 32'h0};  esc_len_d = 3'd2; end
            8'h09: begin esc_d = {"\\t", 32'h0};  esc_len_d = 3'd2; end
            default: ;
          endcase
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ute_pkg::ModeHtml;
      cap_q  <= ute_pkg::CapReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ute_pkg::RegMode) mode_q <= cfg_data_i[1:0];
      else cap_q <= cfg_data_i;
    end
  end

  // Per-string control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_eos_q   <= 1'b0;
      pend_cnt_q  <= 2'd0;
      flush_n_q   <= 2'd0;
      flush_idx_q <= 2'd0;
      len_q       <= '0;
      ovf_seen_q  <= 1'b0;
      ch_n_q      <= 3'd1;
      ch_repl_q   <= 1'b0;
      esc_left_q  <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) cur_eos_q <= end_of_string_i;

      // Held byte count
      if (cmd_i.flush_start || cmd_i.load_full || cmd_i.emit_ovf || cmd_i.clear_str) begin
        pend_cnt_q <= 2'd0;
      end else if (cmd_i.append) begin
        pend_cnt_q <= pend_cnt_q + 2'd1;
      end else if (cmd_i.start_pend) begin
        pend_cnt_q <= 2'd1;
      end

      // Flush queue over the held bytes
      if (cmd_i.flush_start) begin
        flush_n_q   <= pend_cnt_q;
        flush_idx_q <= 2'd0;
      end else if (cmd_i.load_pend) begin
        flush_idx_q <= flush_idx_q + 2'd1;
      end

      if (cmd_i.load_pend || cmd_i.load_fresh || cmd_i.load_full) begin
        ch_n_q    <= ch_n_d;
        ch_repl_q <= cmd_i.load_pend || (cmd_i.load_fresh && cur_byte_q[7]);
      end

      // Running length and overflow flag
      if (cmd_i.clear_str) len_q <= '0;
      else if (cmd_i.emit) len_q <= len_q + 1'b1;

      if (cmd_i.clear_str) ovf_seen_q <= 1'b0;
      else if (cmd_i.emit_ovf) ovf_seen_q <= 1'b1;

      if (cmd_i.build) esc_left_q <= esc_len_d;
      else if (cmd_i.emit) esc_left_q <= esc_left_q - 3'd1;

      // Output register: load on a send, drop once taken
      if (cmd_i.emit || cmd_i.emit_ovf || cmd_i.emit_term) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cur_byte_q <= data_byte_i;
    if (cmd_i.start_pend) pend_q[0] <= cur_byte_q;
    if (cmd_i.append) pend_q[pend_cnt_q] <= cur_byte_q;
    if (cmd_i.load_pend || cmd_i.load_fresh || cmd_i.load_full) ch_q <= ch_d;
    if (cmd_i.build) esc_q <= esc_d;
    else if (cmd_i.emit) esc_q <= {esc_q[39:0], 8'h0};
    if (cmd_i.emit) begin
      out_byte_q  <= esc_q[47:40];
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_total_q <= 16'h0;
    end else if (cmd_i.emit_ovf) begin
      out_byte_q  <= 8'h00;
      out_last_q  <= 1'b1;
      out_ovf_q   <= 1'b1;
      out_total_q <= len_q[15:0];
    end else if (cmd_i.emit_term) begin
      out_byte_q  <= 8'h00;
      out_last_q  <= 1'b1;
      out_ovf_q   <= 1'b0;
      out_total_q <= 16'(len_q + 1'b1);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign is_last_o      = out_last_q;
  assign overflow_o     = out_ovf_q;
  assign total_length_o = out_total_q;

endmodule

@@ hw/rtl/ute_ctrl.sv @@
// Controller of the UTF-8 text escape encoder: sequences one input word
// through decode, flush, capacity check and byte emission.
// Depends on ute_pkg; drives ute_datapath through ute_pkg::cmd_t.
module ute_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ute_pkg::sts_t sts_i,
  output ute_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDecide = 4'd1;
  localparam logic [3:0] StFlush  = 4'd2;
  localparam logic [3:0] StFresh  = 4'd3;
  localparam logic [3:0] StCheck  = 4'd4;
  localparam logic [3:0] StEmit   = 4'd5;
  localparam logic [3:0] StEnd    = 4'd6;
  localparam logic [3:0] StOvf    = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       in_flush_q, in_flush_d;

  assign in_ready_o = (state_q == StIdle);

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_flush_d = in_flush_q;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StDecide;
        end
      end
      StDecide: begin
        if (sts_i.ovf_seen) begin
          state_d = StDone;
        end else if (sts_i.eos) begin
          if (sts_i.pend_nz) begin
            cmd_o.flush_start = 1'b1;
            in_flush_d        = 1'b1;
            state_d           = StFlush;
          end else begin
            state_d = StEnd;
          end
        end else if (sts_i.pend_nz) begin
          if (sts_i.cont_ok && sts_i.complete) begin
            cmd_o.load_full = 1'b1;
            state_d         = StCheck;
          end else if (sts_i.cont_ok) begin
            cmd_o.append = 1'b1;
            state_d      = StDone;
          end else begin
            // Broken sequence: replace the held bytes first
            cmd_o.flush_start = 1'b1;
            in_flush_d        = 1'b1;
            state_d           = StFlush;
          end
        end else begin
          state_d = StFresh;
        end
      end
      StFlush: begin
        if (sts_i.flush_more) begin
          cmd_o.load_pend = 1'b1;
          state_d         = StCheck;
        end else begin
          in_flush_d = 1'b0;
          state_d    = sts_i.eos ? StEnd : StFresh;
        end
      end
      StFresh: begin
        if (sts_i.lead_ok) begin
          cmd_o.start_pend = 1'b1;
          state_d          = StDone;
        end else begin
          cmd_o.load_fresh = 1'b1;
          state_d          = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.fits) begin
          cmd_o.build = 1'b1;
          state_d     = StEmit;
        end else begin
          state_d = StOvf;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.esc_last) state_d = in_flush_q ? StFlush : StDone;
        end
      end
      StEnd: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ovf  = sts_i.len_ge_cap;
          cmd_o.emit_term = ~sts_i.len_ge_cap;
          state_d         = StDone;
        end
      end
      StOvf: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ovf = 1'b1;
          state_d        = StDone;
        end
      end
      StDone: begin
        // End of string resets the per-string state
        cmd_o.clear_str = sts_i.eos;
        in_flush_d      = 1'b0;
        state_d         = StIdle;
      end
      default: begin
        in_flush_d = 1'b0;
        state_d    = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_flush_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_flush_q <= in_flush_d;
    end
  end

endmodule

@@ hw/rtl/utf8_text_escape_encoder_top.sv @@
// Top level of the UTF-8 text escape encoder: controller plus datapath.
// Depends on ute_pkg, ute_ctrl and ute_datapath.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    data_byte, end_of_string
//   out      output     out_valid/out_ready  out_byte, is_last, overflow, total_length
//   cfg      input      cfg_we (no wait)     cfg_idx, cfg_data
//
// One input word at a time. A lead byte is held and a continuation byte appended;
// a byte that yields output passes the capacity check and then emits its bytes,
// after any held bytes that it breaks are replaced first. End of string sends the
// terminator or the overflow word after replacing any held bytes. Reset clears all
// control state at once; no clearing pass. A stalled output register holds its
// word and the sequencer waits on it; the input side is ready only when idle.
module utf8_text_escape_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_last_o,
  output logic        overflow_o,
  output logic [15:0] total_length_o
);

  ute_pkg::cmd_t cmd;
  ute_pkg::sts_t sts;

  ute_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ute_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .is_last_o       (is_last_o),
    .overflow_o      (overflow_o),
    .total_length_o  (total_length_o)
  );

  // Overflow word is always the last of its string
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> is_last_o)
    else $error("overflow word without is_last");

  // Only the final word carries a length
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> total_length_o == 16'h0)
    else $error("length on a non-final word");

  // One input word at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  // A send only happens into a free output register
  a_send_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_ovf || cmd.emit_term) |-> sts.out_free)
    else $error("output register overwritten");

endmodule

@@ tb/sv/ute_escape_checker.sv @@
// Checker for the UTF-8 text escape encoder: watches the config, input and output ports,
// predicts the escaped words of every accepted input word and compares them in order.
// Depends on ute_pkg for the mode and register index constants.
`timescale 1ns / 100ps

module ute_escape_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        is_last_i,
  input  logic        overflow_i,
  input  logic [15:0] total_length_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  // Characters with special meaning in at least one mode
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDel   = 8'h7F;
  // Private-use replacement U+E000 + byte: lead byte and continuation marker
  localparam logic [7:0] PuaLead = 8'hEE;
  localparam logic [7:0] PuaCont = 8'h80;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        ovf;
    logic [15:0] total;
  } esc_word_t;

  esc_word_t escaped_q[$];

  // Predictor state
  logic [1:0]  mode_q;
  logic [15:0] cap_q;
  logic [7:0]  held[3];
  int          held_n;
  int          used_len;
  bit          ovf_seen;
  bit          halted;

  task automatic push_word(input logic [7:0] data, input logic last, input logic ovf,
                           input logic [15:0] total);
    esc_word_t w;
    w.data  = data;
    w.last  = last;
    w.ovf   = ovf;
    w.total = total;
    escaped_q.push_back(w);
  endtask

  task automatic mark_overflow();
    push_word(8'h00, 1'b1, 1'b1, used_len[15:0]);
    ovf_seen = 1'b1;
    held_n   = 0;
    halted   = 1'b1;
  endtask

  // Byte count of a character from its first byte, zero if it cannot start one
  function automatic int char_len(input logic [7:0] lead);
    int n;
    n = 0;
    if (lead >= 8'hC2 && lead <= 8'hDF) n = 2;
    else if (lead >= 8'hE0 && lead <= 8'hEF) n = 3;
    else if (lead >= 8'hF0 && lead <= 8'hF4) n = 4;
    return n;
  endfunction

  // Legal continuation at position pos; the second byte is narrowed for some leads
  function automatic bit follows(input logic [7:0] lead, input int pos, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 1) begin
      case (lead)
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    return (b >= lo) && (b <= hi);
  endfunction

  // Escape one complete character, or replace a single byte
  task automatic escape_char(input logic [3:0][7:0] ch, input int n, input bit repl);
    logic [7:0] c;
    logic [7:0] txt[$];
    int         need;
    int         reserve;
    bit         do_repl;
    string      s;
    if (halted) return;
    c = ch[0];
    do_repl = repl;
    if (n == 1 && ((c < ChSpace && c != ChTab && c != ChCr && c != ChLf) || c == ChDel))
      do_repl = 1'b1;
    reserve = (mode_q == ute_pkg::ModeJson) ? 2 : 6;
    need = do_repl ? 3 : n;
    if (need < reserve) need = reserve;
    if (used_len + need >= int'(cap_q)) begin
      mark_overflow();
      return;
    end
    s = "";
    if (do_repl) begin
      txt.push_back(PuaLead);
      txt.push_back(PuaCont | {6'd0, c[7:6]});
      txt.push_back(PuaCont | {2'd0, c[5:0]});
    end else begin
      case (mode_q)
        ute_pkg::ModeHtml, ute_pkg::ModeXml: begin
          case (c)
            ChLt:    s = "&lt;";
            ChGt:    s = "&gt;";
            ChAmp:   s = "&amp;";
            ChQuote: s = "&quot;";
            ChApos:  s = (mode_q == ute_pkg::ModeXml) ? "&apos;" : "&#x27;";
            default: ;
          endcase
        end
        ute_pkg::ModeJs: begin
          if (c == ChApos) s = "\\'";
          else if (c == ChQuote) s = "\\\"";
          else if (c == ChCr) s = "\\r";
          else if (c == ChLf) s = "\\n";
          else if (n == 3 && c == 8'hE2 && ch[1] == 8'h80 && ch[2] == 8'hA8) s = "\\u2028";
          else if (n == 3 && c == 8'hE2 && ch[1] == 8'h80 && ch[2] == 8'hA9) s = "\\u2029";
        end
        default: begin
          if (c == ChQuote) s = "\\\"";
          else if (c == ChBslash) s = "\\\\";
          else if (c == ChCr) s = "\\r";
          else if (c == ChLf) s = "\\n";
          else if (c == ChTab) s = "\\t";
        end
      endcase
      if (s.len() > 0) begin
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      end else begin
        for (int i = 0; i < n; i++) txt.push_back(ch[i]);
      end
    end
    foreach (txt[i]) push_word(txt[i], 1'b0, 1'b0, 16'd0);
    used_len += txt.size();
  endtask

  // Replace every held byte in order
  task automatic flush_held();
    logic [3:0][7:0] one;
    int              n;
    n = held_n;
    held_n = 0;
    for (int i = 0; i < n; i++) begin
      one = '0;
      one[0] = held[i];
      escape_char(one, 1, 1'b1);
    end
  endtask

  task automatic feed_byte(input logic [7:0] b);
    logic [3:0][7:0] ch;
    int              want;
    ch = '0;
    if (held_n > 0) begin
      want = char_len(held[0]);
      if (follows(held[0], held_n, b)) begin
        if (held_n + 1 >= want) begin
          ch[0] = held[0];
          ch[1] = held[1];
          ch[2] = held[2];
          ch[held_n] = b;
          held_n = 0;
          escape_char(ch, want, 1'b0);
        end else begin
          held[held_n] = b;
          held_n++;
        end
        return;
      end
      // broken sequence: drop the held bytes as replacements, restart on b
      flush_held();
      if (halted) return;
    end
    ch = '0;
    ch[0] = b;
    if (b < 8'h80) begin
      escape_char(ch, 1, 1'b0);
    end else if (char_len(b) != 0) begin
      held[0] = b;
      held_n = 1;
    end else begin
      escape_char(ch, 1, 1'b1);
    end
  endtask

  // Work out all escaped words caused by one input word
  task automatic predict_word(input logic [7:0] b, input logic eos);
    halted = 1'b0;
    if (eos) begin
      if (!ovf_seen) begin
        flush_held();
        if (!halted) begin
          if (used_len >= int'(cap_q)) mark_overflow();
          else push_word(8'h00, 1'b1, 1'b0, 16'(used_len + 1));
        end
      end
      held_n   = 0;
      used_len = 0;
      ovf_seen = 1'b0;
    end else if (!ovf_seen) begin
      feed_byte(b);
    end
  endtask

  // Watch all ports at the rising edge: compare outputs, then track config and inputs
  always @(posedge clk_i or negedge rst_ni) begin : watch
    esc_word_t w;
    if (!rst_ni) begin
      mode_q   = ute_pkg::ModeHtml;
      cap_q    = ute_pkg::CapReset;
      held     = '{8'h00, 8'h00, 8'h00};
      held_n   = 0;
      used_len = 0;
      ovf_seen = 1'b0;
      halted   = 1'b0;
      escaped_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected output word: out_byte 0x%02h is_last %0b overflow %0b total %0d",
                 out_byte_i, is_last_i, overflow_i, total_length_i);
          fail_count_o++;
        end else begin
          w = escaped_q.pop_front();
          checked_o++;
          if (out_byte_i !== w.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", w.data, out_byte_i);
            fail_count_o++;
          end
          if (is_last_i !== w.last) begin
            $error("is_last: expected %0b, actual %0b", w.last, is_last_i);
            fail_count_o++;
          end
          if (overflow_i !== w.ovf) begin
            $error("overflow: expected %0b, actual %0b", w.ovf, overflow_i);
            fail_count_o++;
          end
          if (total_length_i !== w.total) begin
            $error("total_length: expected %0d, actual %0d", w.total, total_length_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == ute_pkg::RegMode) mode_q = cfg_data_i[1:0];
        else cap_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) predict_word(data_byte_i, end_of_string_i);
      pending_o = escaped_q.size();
    end
  end

endmodule

@@ tb/sv/utf8_text_escape_encoder_top_tb.sv @@
// Testbench top of the UTF-8 text escape encoder: clock, reset, string stimulus and verdict.
// Depends on ute_pkg, utf8_text_escape_encoder_top and ute_escape_checker.
`timescale 1ns / 100ps

module utf8_text_escape_encoder_top_tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_string;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        is_last;
  logic        overflow;
  logic [15:0] total_length;

  int fail_count;
  int pending_words;
  int checked_words;

  bit         calm;        // no gaps and no stalls in this stretch
  int         hold_req;    // long output hold-off requested from the receiver
  int         words_sent;
  int         strings_sent;
  logic [7:0] text_q[$];

  utf8_text_escape_encoder_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_string_i(end_of_string),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .is_last_o      (is_last),
    .overflow_o     (overflow),
    .total_length_o (total_length)
  );

  ute_escape_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_string_i(end_of_string),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_i     (out_byte),
    .is_last_i      (is_last),
    .overflow_i     (overflow),
    .total_length_i (total_length),
    .fail_count_o   (fail_count),
    .pending_o      (pending_words),
    .checked_o      (checked_words)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Drain the output: random stalls per word, one long hold-off on request
  initial begin : drain
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(4, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(4, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Send the queued text followed by an end-of-string word with a random data byte
  task automatic send_string();
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    send_word(8'($urandom_range(255, 0)), 1'b1);
    strings_sent++;
    text_q.delete();
  endtask

  // Drop valid and wait until every expected word is out and the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Valid continuation byte; the second byte is narrowed for some leads
  function automatic logic [7:0] cont_byte(input logic [7:0] lead, input int pos);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 1) begin
      case (lead)
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    return 8'($urandom_range(hi, lo));
  endfunction

  // Second byte just outside the legal range of a narrowed lead
  function automatic logic [7:0] bad_second(input logic [7:0] lead);
    logic [7:0] b;
    case (lead)
      8'hE0:   b = 8'($urandom_range(8'h9F, 8'h80));
      8'hED:   b = 8'($urandom_range(8'hBF, 8'hA0));
      8'hF0:   b = 8'($urandom_range(8'h8F, 8'h80));
      default: b = 8'($urandom_range(8'hBF, 8'h90));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] special_char();
    logic [7:0] c;
    case ($urandom_range(8, 0))
      0: c = "<";
      1: c = ">";
      2: c = "&";
      3: c = "\"";
      4: c = "'";
      5: c = "\\";
      6: c = 8'h0D;
      7: c = 8'h0A;
      default: c = 8'h09;
    endcase
    return c;
  endfunction

  task automatic add_valid_char(input int nbytes);
    logic [7:0] lead;
    case (nbytes)
      2: lead = 8'($urandom_range(8'hDF, 8'hC2));
      3: lead = ($urandom_range(2, 0) == 0) ? ($urandom_range(1, 0) ? 8'hE0 : 8'hED)
                                             : 8'($urandom_range(8'hEF, 8'hE0));
      default: lead = 8'($urandom_range(8'hF4, 8'hF0));
    endcase
    text_q.push_back(lead);
    for (int pos = 1; pos < nbytes; pos++) text_q.push_back(cont_byte(lead, pos));
  endtask

  // Append one character: mostly well formed, some noise and broken sequences
  task automatic add_random_char();
    logic [7:0] lead;
    int         nc;
    case ($urandom_range(19, 0))
      0, 1, 2, 3, 4, 5: text_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
      6, 7, 8: text_q.push_back(special_char());
      9: text_q.push_back(($urandom_range(7, 0) == 0) ? 8'h7F : 8'($urandom_range(31, 0)));
      10, 11: add_valid_char(2);
      12, 13: add_valid_char(3);
      14: add_valid_char(4);
      15: begin
        text_q.push_back(8'hE2);
        text_q.push_back(8'h80);
        text_q.push_back($urandom_range(1, 0) ? 8'hA8 : 8'hA9);
      end
      16: begin
        // truncated character, cut by an ordinary byte or by the string end
        lead = $urandom_range(1, 0) ? 8'($urandom_range(8'hEF, 8'hE0))
                                    : 8'($urandom_range(8'hF4, 8'hF0));
        nc = (lead >= 8'hF0) ? $urandom_range(2, 0) : $urandom_range(1, 0);
        text_q.push_back(lead);
        for (int pos = 1; pos <= nc; pos++) text_q.push_back(cont_byte(lead, pos));
        if ($urandom_range(2, 0) != 0)
          text_q.push_back($urandom_range(1, 0) ? special_char()
                                                : 8'($urandom_range(8'hF4, 8'hC2)));
      end
      17: begin
        case ($urandom_range(3, 0))
          0: lead = 8'hE0;
          1: lead = 8'hED;
          2: lead = 8'hF0;
          default: lead = 8'hF4;
        endcase
        text_q.push_back(lead);
        text_q.push_back(bad_second(lead));
      end
      18: begin
        if ($urandom_range(1, 0)) text_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else if ($urandom_range(1, 0)) text_q.push_back(8'($urandom_range(8'hC1, 8'hC0)));
        else text_q.push_back(8'($urandom_range(8'hFF, 8'hF5)));
      end
      default: text_q.push_back(8'($urandom_range(255, 0)));
    endcase
  endtask

  // Main stimulus
  initial begin : stim
    int         phase;
    int         nstr;
    int         nchar;
    logic [1:0] mode;
    logic [15:0] cap;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = ute_pkg::RegMode;
    cfg_data      = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    end_of_string = 1'b0;
    calm          = 1'b0;
    hold_req      = 0;
    words_sent    = 0;
    strings_sent  = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: html escapes, controls, zero, stray bytes, range edges, broken char
    text_q = '{"<", ">", "&", "\"", "'", 8'h00, 8'h7F, 8'h09, 8'hFF, 8'hC0,
               8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
               8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE2, 8'h80, 8'h41};
    send_string();
    // end of string with two bytes still held
    text_q = '{8'hF0, 8'h90};
    send_string();
    settle();

    // Capacity lowered mid-string: no room left for the terminator
    write_reg(ute_pkg::RegCap, 16'd40);
    text_q = '{"a", "b", "c", "d"};
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    text_q.delete();
    settle();
    write_reg(ute_pkg::RegCap, 16'd4);
    send_word(8'hFF, 1'b1);
    strings_sent++;
    settle();

    // Random phases over all modes and a spread of capacities
    phase = 0;
    while (words_sent < 370) begin
      mode = phase[1:0];
      case (phase % 6)
        0: cap = ute_pkg::CapReset;
        1: cap = 16'($urandom_range(120, 8));
        2: cap = 16'hFFFF;
        3: cap = 16'($urandom_range(4096, 1));
        4: cap = 16'($urandom_range(60, 8));
        default: cap = 16'($urandom_range(2, 0));
      endcase
      write_reg(ute_pkg::RegMode, {14'd0, mode});
      write_reg(ute_pkg::RegCap, cap);
      calm = ($urandom_range(3, 0) == 0);
      // hold the output long enough for the block to back up into its input
      if (phase == 3) hold_req = 300;
      nstr = $urandom_range(3, 1);
      for (int s = 0; s < nstr; s++) begin
        nchar = $urandom_range(10, 0);
        for (int c = 0; c < nchar; c++) add_random_char();
        send_string();
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    $display("Sent %0d input words in %0d strings across all four escape modes,", words_sent,
             strings_sent);
    $display("capacities from 0 to 65535; %0d output words checked.", checked_words);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
